// ===== src/jdd_pkg.sv =====
// Shared types, constants and the arctangent table of the joystick direction decoder.
// No dependencies; every other file of the block imports this package.
package jdd_pkg;

    // Fixed-point width of the rotation datapath: degrees and vector parts, Q12.
    localparam int AngW = 23;
    localparam int FracW = 12;
    localparam int MaxSteps = 24;

    typedef logic signed [AngW-1:0] t_ang;
    typedef logic signed [8:0] t_ofs;
    typedef logic signed [4:0] t_dir;

    typedef struct packed {
        logic valid;
        t_ang x;
        t_ang y;
        t_ang z;
    } t_rot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROT,
        ST_DIV,
        ST_HOLD
    } t_state;

    localparam logic [7:0] Centre = 8'd127;
    localparam logic [8:0] SmallOfs = 9'd5;
    localparam logic [7:0] DeadZoneReset = 8'd10;
    localparam t_dir DirNone = 5'sh1F;
    localparam t_dir DirAhead = 5'sd15;
    localparam t_ang Deg180Q12 = t_ang'(180 * 4096);
    localparam t_ang Deg360Q12 = t_ang'(360 * 4096);
    localparam t_ang HalfDegQ12 = t_ang'(2048);
    localparam logic [13:0] RecipThree = 14'd171;

    // atan(2^-i) in degrees, Q12, rounded to nearest.
    function automatic t_ang atan_q12(input int unsigned idx);
        t_ang val;
        unique case (idx)
            0: val = t_ang'(184320);
            1: val = t_ang'(108810);
            2: val = t_ang'(57492);
            3: val = t_ang'(29184);
            4: val = t_ang'(14649);
            5: val = t_ang'(7331);
            6: val = t_ang'(3667);
            7: val = t_ang'(1833);
            8: val = t_ang'(917);
            9: val = t_ang'(458);
            10: val = t_ang'(229);
            11: val = t_ang'(115);
            12: val = t_ang'(57);
            13: val = t_ang'(29);
            14: val = t_ang'(14);
            15: val = t_ang'(7);
            16: val = t_ang'(4);
            17: val = t_ang'(2);
            18: val = t_ang'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== src/jdd_cell.sv =====
// One rotation cell of the vectoring chain: a single fixed-shift micro-rotation.
// Depends on jdd_pkg for the stage type and the arctangent table.
module jdd_cell #(
    parameter int STEP = 0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  jdd_pkg::t_rot i_stage,
    output jdd_pkg::t_rot o_stage
);
    import jdd_pkg::*;

    localparam t_ang AtanStep = atan_q12(STEP);

    t_rot r_stage;
    t_rot n_stage;
    t_ang w_dx;
    t_ang w_dy;

    assign w_dx = i_stage.y >>> STEP;
    assign w_dy = i_stage.x >>> STEP;

    // Rotate towards the x axis; the sign of y picks the direction.
    always_comb begin
        n_stage.valid = i_stage.valid;
        if (!i_stage.y[AngW-1]) begin
            n_stage.x = i_stage.x + w_dx;
            n_stage.y = i_stage.y - w_dy;
            n_stage.z = i_stage.z + AtanStep;
        end else begin
            n_stage.x = i_stage.x - w_dx;
            n_stage.y = i_stage.y + w_dy;
            n_stage.z = i_stage.z - AtanStep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.x <= n_stage.x;
        r_stage.y <= n_stage.y;
        r_stage.z <= n_stage.z;
    end

    assign o_stage = r_stage;

endmodule

// ===== src/joystick_direction_decoder.sv =====
// Top level of the joystick direction decoder: input decode, rotation chain and output register.
// Depends on jdd_pkg and on jdd_cell.
//
// The decoder takes one controller sample at a time and returns one result per sample. A
// sample whose direction follows from a simple check (controller absent, stick inside the dead
// zone or within four counts of centre on both axes, or pushed straight ahead) gets its
// direction in the prepare state and skips the rotation. Any other sample walks through a
// chain of CORDIC_STEPS rotation cells, one cell per cycle, followed by a rounding stage and a
// divide stage. Either kind then waits in the hold state until its result is loaded into the
// output register, and the next sample can be transferred only once the decoder is idle again.
// The chain holds one sample at a time, because the previous-direction field of a sample
// depends on the direction decided for the sample before it. A finished result waits in the
// output register, so the next sample may be transferred while the result is still unread;
// that sample's result then waits until the register has been emptied. The dead-zone register
// is written through its own channel, which is always ready; it resets to 10.
module joystick_direction_decoder #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: dead_zone.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // Sample stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // button_bits[7:0], stick_x[15:8], stick_y[23:16]
    input  logic        s_axis_tuser,   // connected
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // button_a[0], button_b[1], stick_button[2],
                                        // direction[7:3], previous_direction[12:8], zero[15:13]
);
    import jdd_pkg::*;

    // Control state and configuration.
    t_state r_state;
    t_state n_state;
    logic [7:0] r_dz;
    t_dir r_cur;
    t_dir r_prior;

    // Sample held for the duration of its processing.
    logic r_conn;
    logic [2:0] r_btn;
    t_ofs r_h;
    t_ofs r_v;

    // Intermediate results.
    logic [8:0] r_deg;
    t_dir r_res_dir;

    // Output register.
    logic r_m_valid;
    logic [15:0] r_m_data;

    // Control strobes from the state machine.
    logic w_accept;
    logic w_launch;
    logic w_set_bypass;
    logic w_set_deg;
    logic w_set_div;
    logic w_commit;
    logic w_out_free;

    // Decode of the held sample.
    logic [8:0] w_abs_h;
    logic [8:0] w_abs_v;
    logic w_in_dz;
    logic w_small;
    logic w_ahead;
    logic w_bypass;
    t_dir w_bypass_dir;

    // Rotation chain.
    t_rot w_chain [0:CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0] w_vld;
    logic signed [20:0] w_xs;
    logic signed [20:0] w_ys;
    t_ang w_x0;
    t_ang w_y0;

    // Final rounding and scaling.
    t_ang w_zf;
    t_ang w_rnd;
    logic [5:0] w_q;
    logic [13:0] w_prod;
    t_dir w_new_prior;
    logic [2:0] w_new_btn;

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz <= DeadZoneReset;
        end else if (i_cfg_valid) begin
            r_dz <= i_cfg_data;
        end
    end

    // Capture the sample; the axes become signed offsets from centre.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_conn <= s_axis_tuser;
            r_btn <= s_axis_tdata[2:0];
            r_h <= $signed({1'b0, s_axis_tdata[15:8]}) - $signed({1'b0, Centre});
            r_v <= $signed({1'b0, s_axis_tdata[23:16]}) - $signed({1'b0, Centre});
        end
    end

    // Checks that settle the direction without a rotation.
    assign w_abs_h = r_h[8] ? 9'(-r_h) : 9'(r_h);
    assign w_abs_v = r_v[8] ? 9'(-r_v) : 9'(r_v);
    assign w_in_dz = (w_abs_h < {1'b0, r_dz}) && (w_abs_v < {1'b0, r_dz});
    assign w_small = (w_abs_h < SmallOfs) && (w_abs_v < SmallOfs);
    assign w_ahead = (r_h == '0) && !r_v[8] && (r_v != '0);
    assign w_bypass = !r_conn || w_in_dz || w_small || w_ahead;

    always_comb begin
        priority if (!r_conn || w_in_dz || w_small) begin
            w_bypass_dir = DirNone;
        end else begin
            w_bypass_dir = DirAhead;
        end
    end

    // Pre-rotation: a vector in the lower half-plane is turned through half a circle.
    assign w_xs = $signed({r_v, 12'b0});
    assign w_ys = $signed({r_h, 12'b0});
    assign w_x0 = r_v[8] ? -t_ang'(w_xs) : t_ang'(w_xs);
    assign w_y0 = r_v[8] ? -t_ang'(w_ys) : t_ang'(w_ys);

    always_comb begin
        w_chain[0].valid = w_launch;
        w_chain[0].x = w_x0;
        w_chain[0].y = w_y0;
        w_chain[0].z = r_v[8] ? Deg180Q12 : '0;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        jdd_cell #(
            .STEP(g)
        ) u_cell (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_stage(w_chain[g]),
            .o_stage(w_chain[g+1])
        );
        assign w_vld[g] = w_chain[g+1].valid;
    end

    // Fold the angle into one turn and round to whole degrees.
    assign w_zf = w_chain[CORDIC_STEPS].z[AngW-1] ? w_chain[CORDIC_STEPS].z + Deg360Q12
                                                  : w_chain[CORDIC_STEPS].z;
    assign w_rnd = w_zf + HalfDegQ12;

    always_ff @(posedge i_clk) begin
        if (w_set_deg) begin
            r_deg <= w_rnd[FracW+8:FracW];
        end
    end

    // Fifteen codes per full turn: deg * 15 / 360 is deg / 24, taken as (deg / 8) / 3
    // with a reciprocal multiply that is exact for quotients up to 45.
    assign w_q = r_deg[8:3];
    assign w_prod = 14'(w_q) * RecipThree;

    always_ff @(posedge i_clk) begin
        if (w_set_bypass) begin
            r_res_dir <= w_bypass_dir;
        end else if (w_set_div) begin
            r_res_dir <= t_dir'({1'b0, w_prod[12:9]});
        end
    end

    // State machine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_launch = 1'b0;
        w_set_bypass = 1'b0;
        w_set_deg = 1'b0;
        w_set_div = 1'b0;
        w_commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (w_bypass) begin
                    w_set_bypass = 1'b1;
                    n_state = ST_HOLD;
                end else begin
                    w_launch = 1'b1;
                    n_state = ST_ROT;
                end
            end
            ST_ROT: begin
                if (w_chain[CORDIC_STEPS].valid) begin
                    w_set_deg = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                w_set_div = 1'b1;
                n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // An absent controller keeps the previous direction and reads no buttons.
    assign w_new_prior = r_conn ? r_cur : r_prior;
    assign w_new_btn = r_conn ? r_btn : 3'b000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= DirNone;
            r_prior <= DirNone;
        end else if (w_commit) begin
            r_cur <= r_res_dir;
            r_prior <= w_new_prior;
        end
    end

    // Output register: loaded on commit, emptied when the result transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_commit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_m_data <= {3'b000, w_new_prior, r_res_dir, w_new_btn};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata = r_m_data;

    // The chain carries at most one sample at a time.
    a_chain_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one sample in the rotation chain");

    // A rotation result only arrives while the state machine waits for it.
    a_chain_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[CORDIC_STEPS].valid |-> r_state == ST_ROT)
        else $error("rotation result outside the rotation state");

    // An absent controller gives no direction and no buttons.
    a_absent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && !r_conn) |=> (m_axis_tdata[7:3] == 5'h1F && m_axis_tdata[2:0] == 3'b000))
        else $error("absent controller produced a direction or a button");

    // Every direction code delivered is a valid one.
    a_dir_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[7] || m_axis_tdata[7:3] == 5'h1F))
        else $error("direction code out of range");

endmodule
